// ----- rtl/mco_pkg.sv -----
package mco_pkg;

	// Field widths of the dimension and cost transactions
	localparam int DIM_BITS = 10;
	localparam int COST_W   = 40;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_MANY = 2'd2,
		ST_SAT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] dimension;
		logic                is_last;
	} dim_item_t;

	typedef struct packed {
		logic [COST_W-1:0] min_cost;
		status_t           status;
	} cost_item_t;

endpackage

// ----- rtl/matrix_chain_order_cost_unit.sv -----
// Matrix chain order cost unit. Dimensions of a chain arrive one per transaction, one
// per cycle while dim_stall is low, and are kept in a dimension RAM; the transaction
// flagged is_last closes the chain. A chain of fewer than two or more than MAX_DIMS
// dimensions gives cost 0 with status FEW or MANY through the result register and the
// output register. Otherwise the unit fills the span cost table bottom-up in a cost
// RAM, using one shared multiplier and one shared saturating adder under a sequencer,
// and meanwhile stalls the input. The steps of each split are set by the single read
// port of each RAM and the two passes through the multiplier and the adder; each span
// and each row adds steps of its own. Costs saturate at 2^40-1 with status SAT. The
// result waits in an output register while the next chain loads.
module matrix_chain_order_cost_unit import mco_pkg::*; #(
	parameter int MAX_DIMS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dim_valid,
	output logic       dim_stall,
	input  dim_item_t  dim_data,
	output logic       cost_valid,
	input  logic       cost_stall,
	output cost_item_t cost_data
);

	localparam int IW    = $clog2(MAX_DIMS);
	localparam int CW    = $clog2(MAX_DIMS + 1);
	localparam int CT_AW = 2 * IW;
	localparam int PW    = COST_W + DIM_BITS;

	typedef enum logic [3:0] {
		S_LOAD, S_ROW, S_J0, S_J1, S_J2, S_K0, S_K1, S_K2, S_K3, S_K4,
		S_JW, S_RES0, S_RES1, S_EMIT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [IW-1:0]     nm1_q, i_q, j_q, k_q;
	logic [DIM_BITS-1:0] a_q, c_q;
	logic [COST_W-1:0] p_q, left_q, right_q, sum_q, best_q;
	cost_item_t        res_q;
	logic              out_valid_q;
	cost_item_t        out_q;

	logic                accept;
	logic                dim_wr_en, dim_rd_en;
	logic [IW-1:0]       dim_rd_addr;
	logic [DIM_BITS-1:0] dim_rdata;
	logic                ct_wr_en, ct_rd_en;
	logic [CT_AW-1:0]    ct_wr_addr, ct_rd_addr;
	logic [COST_W-1:0]   ct_wr_data, ct_rdata;
	logic [COST_W-1:0]   mul_a;
	logic [DIM_BITS-1:0] mul_b;
	logic [PW-1:0]       mul_prod;
	logic [COST_W-1:0]   mul_sat;
	logic [COST_W-1:0]   add_a, add_b;
	logic [COST_W:0]     add_sum;
	logic [COST_W-1:0]   add_sat;
	logic [CW-1:0]       cnt_inc;
	logic                room;

	assign dim_stall  = (state_q != S_LOAD);
	assign accept     = dim_valid && !dim_stall;
	assign cost_valid = out_valid_q;
	assign cost_data  = out_q;

	assign room    = (cnt_q < CW'(MAX_DIMS));
	assign cnt_inc = cnt_q + CW'(1);

	// Store dimensions while the chain loads
	assign dim_wr_en = accept && room;

	always_comb begin
		dim_rd_addr = k_q;
		case (state_q)
			S_J0:    dim_rd_addr = i_q - IW'(1);
			S_J1:    dim_rd_addr = j_q;
			default: dim_rd_addr = k_q;
		endcase
	end
	assign dim_rd_en = (state_q == S_J0) || (state_q == S_J1) || (state_q == S_K0);

	mco_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_DIMS)) u_dim_ram (
		.clk     (clk),
		.wr_en   (dim_wr_en),
		.wr_addr (cnt_q[IW-1:0]),
		.wr_data (dim_data.dimension),
		.rd_en   (dim_rd_en),
		.rd_addr (dim_rd_addr),
		.rd_data (dim_rdata)
	);

	// Cost table ports: diagonal zero, span result, sub-span and final result reads
	assign ct_wr_en   = (state_q == S_ROW) || (state_q == S_JW);
	assign ct_wr_addr = (state_q == S_ROW) ? {i_q, i_q} : {i_q, j_q};
	assign ct_wr_data = (state_q == S_ROW) ? '0 : best_q;

	always_comb begin
		ct_rd_addr = {i_q, k_q};
		case (state_q)
			S_K1:    ct_rd_addr = {k_q + IW'(1), j_q};
			S_RES0:  ct_rd_addr = {IW'(1), nm1_q};
			default: ct_rd_addr = {i_q, k_q};
		endcase
	end
	assign ct_rd_en = (state_q == S_K0) || (state_q == S_K1) || (state_q == S_RES0);

	mco_ram #(.WIDTH(COST_W), .DEPTH(1 << CT_AW)) u_cost_ram (
		.clk     (clk),
		.wr_en   (ct_wr_en),
		.wr_addr (ct_wr_addr),
		.wr_data (ct_wr_data),
		.rd_en   (ct_rd_en),
		.rd_addr (ct_rd_addr),
		.rd_data (ct_rdata)
	);

	// Shared multiplier: left dim times split dim, then times right dim
	assign mul_a    = (state_q == S_K1) ? COST_W'(a_q) : p_q;
	assign mul_b    = (state_q == S_K1) ? dim_rdata : c_q;
	assign mul_prod = PW'(mul_a) * PW'(mul_b);
	assign mul_sat  = (mul_prod > PW'(COST_MAX)) ? COST_MAX : mul_prod[COST_W-1:0];

	// Shared saturating adder: product plus left cost, then plus right cost
	assign add_a   = (state_q == S_K3) ? p_q : sum_q;
	assign add_b   = (state_q == S_K3) ? left_q : right_q;
	assign add_sum = {1'b0, add_a} + {1'b0, add_b};
	assign add_sat = add_sum[COST_W] ? COST_MAX : add_sum[COST_W-1:0];

	// Sequencer, loader state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !cost_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (dim_data.is_last) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							res_q.min_cost <= '0;
							if (!room || ovf_q) begin
								res_q.status <= ST_MANY;
								state_q      <= S_EMIT;
							end else if (cnt_inc < CW'(2)) begin
								res_q.status <= ST_FEW;
								state_q      <= S_EMIT;
							end else begin
								nm1_q   <= cnt_q[IW-1:0];
								i_q     <= cnt_q[IW-1:0];
								state_q <= S_ROW;
							end
						end else if (room) begin
							cnt_q <= cnt_inc;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_ROW: begin
					j_q <= i_q + IW'(1);
					if (i_q == nm1_q) begin
						if (i_q == IW'(1)) begin
							state_q <= S_RES0;
						end else begin
							i_q <= i_q - IW'(1);
						end
					end else begin
						state_q <= S_J0;
					end
				end
				S_J0: begin
					state_q <= S_J1;
				end
				S_J1: begin
					a_q     <= dim_rdata;
					state_q <= S_J2;
				end
				S_J2: begin
					c_q     <= dim_rdata;
					k_q     <= i_q;
					best_q  <= COST_MAX;
					state_q <= S_K0;
				end
				S_K0: begin
					state_q <= S_K1;
				end
				S_K1: begin
					p_q     <= mul_sat;
					left_q  <= ct_rdata;
					state_q <= S_K2;
				end
				S_K2: begin
					p_q     <= mul_sat;
					right_q <= ct_rdata;
					state_q <= S_K3;
				end
				S_K3: begin
					sum_q   <= add_sat;
					state_q <= S_K4;
				end
				S_K4: begin
					if (add_sat < best_q) begin
						best_q <= add_sat;
					end
					if (k_q == j_q - IW'(1)) begin
						state_q <= S_JW;
					end else begin
						k_q     <= k_q + IW'(1);
						state_q <= S_K0;
					end
				end
				S_JW: begin
					if (j_q == nm1_q) begin
						if (i_q == IW'(1)) begin
							state_q <= S_RES0;
						end else begin
							i_q     <= i_q - IW'(1);
							state_q <= S_ROW;
						end
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_J0;
					end
				end
				S_RES0: begin
					state_q <= S_RES1;
				end
				S_RES1: begin
					res_q.min_cost <= ct_rdata;
					res_q.status   <= (ct_rdata == COST_MAX) ? ST_SAT : ST_OK;
					state_q        <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || !cost_stall) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cost_valid) |-> $past(state_q == S_EMIT))
		else $error("result raised outside the emit step");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid && (cost_data.status == ST_FEW || cost_data.status == ST_MANY)
		|-> cost_data.min_cost == '0)
		else $error("error status with nonzero cost");

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid && (cost_data.status == ST_OK || cost_data.status == ST_SAT)
		|-> ((cost_data.status == ST_SAT) == (cost_data.min_cost == COST_MAX)))
		else $error("saturation status does not match cost");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_DIMS))
		else $error("dimension count beyond store depth");
`endif

endmodule

// ----- rtl/mco_ram.sv -----
module mco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
